// ===== hw/rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion helper macros for the console RTL.
// Define ASSERT_OFF to compile the checks out.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent holds at an edge, consequent holds at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds at an edge, consequent holds at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// ============================================================================
// tcw_pkg
// Types and fixed constants shared by the text console writer.
// ============================================================================
package tcw_pkg;

   // Request codes
   typedef enum logic [1:0] {
      REQ_PUT   = 2'd0,
      REQ_MOVE  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_READ  = 2'd3
   } req_code_type;

   // Character and attribute constants
   localparam logic [7:0] CH_NULL    = 8'd0;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] ATTR_RESET = 8'd7;

   // Request payload
   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [6:0] col;
      logic [4:0] row;
   } req_item_type;

   // Response payload
   typedef struct packed {
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } rsp_item_type;

   // One screen cell as stored
   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] code;
   } cell_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_BLANK,
      ST_READ
   } state_type;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// ============================================================================
// text_console_writer
// Text-mode console: screen memory of character/attribute cells, cursor,
// line wrap and scrolling through a circular row base.
// ============================================================================
//
//   port group   direction  handshake
//   req_*        in         start & !busy accepts one request
//   rsp_*        out        rsp_valid strobe, one cycle, always taken
//   csr_*        in         csr_wr_en writes the text attribute
//
// Put, newline without scroll and move: the block stays idle, response on the next cycle.
// Read cell: the registered read of the screen memory, then the response from ST_READ.
// Scroll: the new bottom row is blanked one cell a cycle in ST_BLANK
// through the single write port, rows themselves never move.
// Clear screen: the same write-port sweep, over every row of the screen.
// After reset a sweep fills the screen; busy stays high until it ends.
// ============================================================================
`include "assert_macros.svh"

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tcw_pkg::req_item_type req_data,
   output logic                 rsp_valid,
   output tcw_pkg::rsp_item_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);
   import tcw_pkg::*;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = ROWS * (2 ** COL_W);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   // Logical row to physical row through the scroll base
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                 input logic [ROW_W-1:0] base);
      logic [ROW_W:0] sum;
      sum = {1'b0, lrow} + {1'b0, base};
      if (sum >= (ROW_W + 1)'(ROWS))
         sum = sum - (ROW_W + 1)'(ROWS);
      return sum[ROW_W-1:0];
   endfunction

   // Registers
   state_type        state_ff, state_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [ROW_W-1:0] base_ff, base_in;
   logic [COL_W-1:0] sweep_col_ff, sweep_col_in;
   logic [ROW_W-1:0] sweep_row_ff, sweep_row_in;
   logic [7:0]       fill_attr_ff, fill_attr_in;
   logic [7:0]       text_attr_ff, text_attr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;
   cell_type         rd_cell_ff;

   // Screen memory
   cell_type         screen_mem [DEPTH];
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   cell_type         mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // Decode of the incoming request
   logic             accept;
   logic             put_newline, put_print, wrap_line, scroll;
   logic             sweep_last_col, sweep_last_row;
   logic [COL_W-1:0] req_col_sat;
   logic [ROW_W-1:0] req_row_sat;

   assign accept      = start && (state_ff == ST_IDLE);
   assign put_newline = (req_data.req_type == REQ_PUT) && (req_data.char_code == CH_NEWLINE);
   assign put_print   = (req_data.req_type == REQ_PUT) && (req_data.char_code != CH_NEWLINE)
                        && (req_data.char_code != CH_NULL);
   assign wrap_line   = put_newline || (put_print && (cur_col_ff == LAST_COL));
   assign scroll      = wrap_line && (cur_row_ff == LAST_ROW);

   assign sweep_last_col = (sweep_col_ff == LAST_COL);
   assign sweep_last_row = (sweep_row_ff == LAST_ROW);

   // Saturate target column and row
   assign req_col_sat = (32'(req_data.col) >= COLUMNS) ? LAST_COL : COL_W'(req_data.col);
   assign req_row_sat = (32'(req_data.row) >= ROWS)    ? LAST_ROW : ROW_W'(req_data.row);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            if (sweep_last_col && sweep_last_row)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_PUT:   state_in = scroll ? ST_BLANK : ST_IDLE;
                  REQ_MOVE:  state_in = ST_IDLE;
                  REQ_CLEAR: state_in = ST_CLEAR;
                  REQ_READ:  state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_BLANK: begin
            if (sweep_last_col)
               state_in = ST_IDLE;
         end
         ST_READ:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and memory port control
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = {sweep_row_ff, sweep_col_ff};
      mem_wdata = '{attr: fill_attr_ff, code: CH_SPACE};
      mem_raddr = {phys_row(req_row_sat, base_ff), req_col_sat};
      unique case (state_ff)
         ST_INIT, ST_CLEAR, ST_BLANK: mem_we = 1'b1;
         ST_IDLE: begin
            if (accept && put_print) begin
               mem_we    = 1'b1;
               mem_waddr = {phys_row(cur_row_ff, base_ff), cur_col_ff};
               mem_wdata = '{attr: text_attr_ff, code: req_data.char_code};
            end
         end
         default: mem_we = 1'b0;
      endcase
   end

   // Cursor, scroll base, sweep counters, attributes and response
   always_comb begin
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      base_in      = base_ff;
      sweep_col_in = sweep_col_ff;
      sweep_row_in = sweep_row_ff;
      fill_attr_in = fill_attr_ff;
      text_attr_in = csr_wr_en ? csr_wr_data : text_attr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            if (sweep_last_col) begin
               sweep_col_in = '0;
               sweep_row_in = sweep_row_ff + ROW_W'(1);
            end else begin
               sweep_col_in = sweep_col_ff + COL_W'(1);
            end
         end
         ST_BLANK: sweep_col_in = sweep_col_ff + COL_W'(1);
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{cursor_col: 7'(cur_col_ff), cursor_row: 5'(cur_row_ff),
                       cell_char: rd_cell_ff.code, cell_attr: rd_cell_ff.attr};
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_PUT: begin
                     if (wrap_line) begin
                        cur_col_in = '0;
                        if (scroll) begin
                           // old top row becomes the new bottom row
                           base_in      = (base_ff == LAST_ROW) ? '0 : base_ff + ROW_W'(1);
                           sweep_row_in = base_ff;
                           sweep_col_in = '0;
                           fill_attr_in = text_attr_ff;
                        end else begin
                           cur_row_in = cur_row_ff + ROW_W'(1);
                        end
                     end else if (put_print) begin
                        cur_col_in = cur_col_ff + COL_W'(1);
                     end
                  end
                  REQ_MOVE: begin
                     cur_col_in = req_col_sat;
                     cur_row_in = req_row_sat;
                  end
                  REQ_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = LAST_ROW;
                     sweep_col_in = '0;
                     sweep_row_in = '0;
                     fill_attr_in = text_attr_ff;
                  end
                  default: ;
               endcase
               if (req_data.req_type != REQ_READ) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{cursor_col: 7'(cur_col_in), cursor_row: 5'(cur_row_in),
                             cell_char: 8'd0, cell_attr: 8'd0};
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= LAST_ROW;
         base_ff      <= '0;
         sweep_col_ff <= '0;
         sweep_row_ff <= '0;
         fill_attr_ff <= ATTR_RESET;
         text_attr_ff <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         base_ff      <= base_in;
         sweep_col_ff <= sweep_col_in;
         sweep_row_ff <= sweep_row_in;
         fill_attr_ff <= fill_attr_in;
         text_attr_ff <= text_attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Screen memory write port
   always_ff @(posedge clock) begin
      if (mem_we)
         screen_mem[mem_waddr] <= mem_wdata;
   end

   // Screen memory read port
   always_ff @(posedge clock) begin
      rd_cell_ff <= screen_mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ASSERT_IMPLIES(a_cursor_range, clock, reset, 1'b1, (cur_col_ff <= LAST_COL) && (cur_row_ff <= LAST_ROW) && (base_ff <= LAST_ROW), "cursor or scroll base out of range")
   `ASSERT_NEXT(a_rsp_after_req, clock, reset, accept && (req_data.req_type != REQ_READ), rsp_valid, "no response after request")
   `ASSERT_NEXT(a_rsp_after_read, clock, reset, state_ff == ST_READ, rsp_valid && (state_ff == ST_IDLE), "no response after read")
   `ASSERT_IMPLIES(a_no_write_idle, clock, reset, mem_we && (state_ff == ST_IDLE), accept && put_print, "screen written without a put")

endmodule

// ===== dv/text_console_writer_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// text_console_writer_tb
// Self-checking testbench for the text-mode console writer.
// A shadow screen, cursor and attribute are kept in step with every accepted
// request and predict each response. Directed requests cover corner cells,
// saturation, null and newline characters, wrap, scroll, clear and the
// attribute extremes. Random traffic follows under changing attributes, with
// random sender gaps.
// ============================================================================
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int SCREEN_CELLS = COLUMNS * ROWS;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_PHASES    = 5;
   localparam int REQUESTS_A_PHASE = 350;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         start       = 1'b0;
   logic         busy;
   req_item_type req_data    = '0;
   logic         rsp_valid;
   rsp_item_type rsp_data;
   logic         csr_wr_en   = 1'b0;
   logic [7:0]   csr_wr_data = '0;

   // Shadow of the console state
   cell_type     console_screen [SCREEN_CELLS];
   int unsigned  console_col;
   int unsigned  console_row;
   logic [7:0]   console_attr;

   rsp_item_type cursor_reports [$];
   int unsigned  mismatch_count   = 0;
   int unsigned  cycle_count      = 0;
   int unsigned  request_tally [4] = '{0, 0, 0, 0};
   int unsigned  scroll_count     = 0;
   int unsigned  attribute_writes = 0;
   bit           sender_pauses    = 1'b1;

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow screen helpers
   function automatic void blank_screen();
      for (int i = 0; i < SCREEN_CELLS; i++) begin
         console_screen[i] = '{attr: console_attr, code: CH_SPACE};
      end
   endfunction

   // Column 0 of the next row, or scroll when already on the bottom row
   function automatic void advance_line();
      console_col = 0;
      if (console_row >= ROWS - 1) begin
         for (int i = 0; i < SCREEN_CELLS - COLUMNS; i++) begin
            console_screen[i] = console_screen[i + COLUMNS];
         end
         for (int i = SCREEN_CELLS - COLUMNS; i < SCREEN_CELLS; i++) begin
            console_screen[i] = '{attr: console_attr, code: CH_SPACE};
         end
         scroll_count++;
      end else begin
         console_row++;
      end
   endfunction

   // Apply one request to the shadow and return the response it should give
   function automatic rsp_item_type apply_console_request(req_item_type item);
      rsp_item_type reply;
      int unsigned  tgt_col;
      int unsigned  tgt_row;
      cell_type     picked;
      reply   = '0;
      tgt_col = (item.col >= COLUMNS) ? COLUMNS - 1 : item.col;
      tgt_row = (item.row >= ROWS) ? ROWS - 1 : item.row;
      request_tally[item.req_type]++;
      case (req_code_type'(item.req_type))
         REQ_PUT: begin
            if (item.char_code == CH_NEWLINE) begin
               advance_line();
            end else if (item.char_code != CH_NULL) begin
               console_screen[console_row * COLUMNS + console_col] =
                  '{attr: console_attr, code: item.char_code};
               console_col++;
               if (console_col >= COLUMNS) begin
                  advance_line();
               end
            end
         end
         REQ_MOVE: begin
            console_col = tgt_col;
            console_row = tgt_row;
         end
         REQ_CLEAR: begin
            blank_screen();
            console_col = 0;
            console_row = ROWS - 1;
         end
         REQ_READ: begin
            picked          = console_screen[tgt_row * COLUMNS + tgt_col];
            reply.cell_char = picked.code;
            reply.cell_attr = picked.attr;
         end
      endcase
      reply.cursor_col = console_col[6:0];
      reply.cursor_row = console_row[4:0];
      return reply;
   endfunction

   function automatic req_item_type make_request(req_code_type kind, logic [7:0] ch,
                                                 logic [6:0] c, logic [4:0] r);
      req_item_type item;
      item.req_type  = kind;
      item.char_code = ch;
      item.col       = c;
      item.row       = r;
      return item;
   endfunction

   // Random request: mostly text with newlines, some moves and reads, rare clears
   function automatic req_item_type random_request();
      req_item_type item;
      int unsigned  pick;
      int unsigned  sub;
      item.char_code = 8'($urandom_range(0, 255));
      item.col = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(COLUMNS, 127))
                                             : 7'($urandom_range(0, COLUMNS - 1));
      item.row = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(ROWS, 31))
                                             : 5'($urandom_range(0, ROWS - 1));
      pick = $urandom_range(0, 199);
      if (pick < 124) begin
         item.req_type = REQ_PUT;
         sub = $urandom_range(0, 99);
         if (sub < 9) begin
            item.char_code = CH_NEWLINE;
         end else if (sub < 12) begin
            item.char_code = CH_NULL;
         end else if (sub >= 30) begin
            item.char_code = 8'($urandom_range(32, 126));
         end
      end else if (pick < 148) begin
         item.req_type = REQ_MOVE;
      end else if (pick < 150) begin
         item.req_type = REQ_CLEAR;
      end else begin
         item.req_type = REQ_READ;
         // half the reads look back along the line just written
         if (pick < 175) begin
            item.row = 5'(console_row);
            item.col = 7'($urandom_range(0, console_col));
         end
      end
      return item;
   endfunction

   // Send one request: optional gap, then hold start until accepted
   task automatic send_request(input req_item_type item);
      int unsigned gap_cycles;
      gap_cycles = sender_pauses ? $urandom_range(0, 13) : 0;
      if (gap_cycles != 0) begin
         start <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      cursor_reports.push_back(apply_console_request(item));
   endtask

   // Stop sending and wait until every response is in and the block is idle
   task automatic wait_console_idle();
      start <= 1'b0;
      @(posedge clock);
      while (cursor_reports.size() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_text_attribute(input logic [7:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      console_attr  = value;
      attribute_writes++;
      @(posedge clock);
   endtask

   task automatic report_field(input string field_name, input logic [7:0] want,
                               input logic [7:0] got);
      if (mismatch_count < 40) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, field_name, want, got);
      end
   endtask

   // Response checker: every strobe is matched against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (cursor_reports.size() == 0) begin
            if (mismatch_count < 40) begin
               $display("%0t ns: unexpected response, expected none, actual %p",
                        $time, rsp_data);
            end
            mismatch_count++;
         end else begin
            want = cursor_reports.pop_front();
            if (want !== rsp_data) begin
               if (want.cursor_col !== rsp_data.cursor_col) begin
                  report_field("cursor_col", 8'(want.cursor_col), 8'(rsp_data.cursor_col));
               end
               if (want.cursor_row !== rsp_data.cursor_row) begin
                  report_field("cursor_row", 8'(want.cursor_row), 8'(rsp_data.cursor_row));
               end
               if (want.cell_char !== rsp_data.cell_char) begin
                  report_field("cell_char", want.cell_char, rsp_data.cell_char);
               end
               if (want.cell_attr !== rsp_data.cell_attr) begin
                  report_field("cell_attr", want.cell_attr, rsp_data.cell_attr);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Screen straight after the initial fill: corners, saturated coordinates
   task automatic test_reset_screen();
      send_request(make_request(REQ_READ, CH_NULL, 7'd0, 5'd0));
      send_request(make_request(REQ_READ, 8'hFF, 7'd127, 5'd31));
      send_request(make_request(REQ_READ, CH_NULL, 7'(COLUMNS), 5'd0));
      send_request(make_request(REQ_READ, CH_NULL, 7'd0, 5'(ROWS)));
   endtask

   // Null and top-bit characters, newline scroll, line wrap with and without scroll
   task automatic test_put_wrap_scroll();
      send_request(make_request(REQ_PUT, 8'h41, 7'd0, 5'd0));      // 'A'
      send_request(make_request(REQ_PUT, CH_NULL, 7'd127, 5'd31));
      send_request(make_request(REQ_PUT, 8'hFF, 7'd0, 5'd0));
      send_request(make_request(REQ_READ, CH_NULL, 7'd0, 5'd24));
      send_request(make_request(REQ_PUT, CH_NEWLINE, 7'd0, 5'd0));
      send_request(make_request(REQ_READ, CH_NULL, 7'd0, 5'd23));
      send_request(make_request(REQ_MOVE, CH_NULL, 7'd78, 5'd0));
      send_request(make_request(REQ_PUT, 8'h59, 7'd0, 5'd0));      // 'Y'
      send_request(make_request(REQ_PUT, 8'h5A, 7'd0, 5'd0));      // 'Z', wraps
      send_request(make_request(REQ_READ, CH_NULL, 7'd79, 5'd0));
      send_request(make_request(REQ_MOVE, 8'hFF, 7'd127, 5'd31));
      send_request(make_request(REQ_PUT, 8'h71, 7'd0, 5'd0));      // 'q', wraps and scrolls
      send_request(make_request(REQ_READ, CH_NULL, 7'd79, 5'd23));
   endtask

   // Attribute extremes seen through clear, put and the blanked scroll row
   task automatic test_attribute_and_clear();
      wait_console_idle();
      write_text_attribute(8'hFF);
      send_request(make_request(REQ_CLEAR, CH_NULL, 7'd0, 5'd0));
      send_request(make_request(REQ_READ, CH_NULL, 7'd40, 5'd12));
      wait_console_idle();
      write_text_attribute(8'h00);
      send_request(make_request(REQ_PUT, 8'h61, 7'd0, 5'd0));      // 'a'
      send_request(make_request(REQ_PUT, CH_NEWLINE, 7'd0, 5'd0));
      send_request(make_request(REQ_READ, CH_NULL, 7'd0, 5'd24));
      send_request(make_request(REQ_READ, CH_NULL, 7'd0, 5'd23));
   endtask

   // Random traffic in phases, each under its own attribute
   task automatic test_random_traffic();
      logic [7:0] phase_attr;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_console_idle();
         case (phase)
            0:       phase_attr = ATTR_RESET;
            1:       phase_attr = 8'hFF;
            2:       phase_attr = 8'h00;
            default: phase_attr = 8'($urandom_range(0, 255));
         endcase
         write_text_attribute(phase_attr);
         for (int n = 0; n < REQUESTS_A_PHASE; n++) begin
            // stretches without sender gaps now and then
            if (n % 50 == 0) begin
               sender_pauses = ($urandom_range(0, 2) != 0);
            end
            send_request(random_request());
         end
      end
      sender_pauses = 1'b1;
   endtask

   initial begin
      console_attr = ATTR_RESET;
      blank_screen();
      console_col = 0;
      console_row = ROWS - 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_screen();
      test_put_wrap_scroll();
      test_attribute_and_clear();
      test_random_traffic();

      wait_console_idle();
      repeat (2 * COLUMNS) @(posedge clock);
      $display("Ran %0d requests: %0d puts, %0d moves, %0d clears, %0d reads.",
               request_tally[REQ_PUT] + request_tally[REQ_MOVE] + request_tally[REQ_CLEAR]
               + request_tally[REQ_READ], request_tally[REQ_PUT], request_tally[REQ_MOVE],
               request_tally[REQ_CLEAR], request_tally[REQ_READ]);
      $display("Screen scrolled %0d times under %0d attribute settings; %0d mismatches.",
               scroll_count, attribute_writes, mismatch_count);
      if (mismatch_count == 0 && cursor_reports.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
